// ===== hw/rtl/b64e_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg: shared types and constants of the base64 encoder
// Character job record, queue depth default and the alphabet lookup.
// ----------------------------------------------------------------------------
package b64e_pkg;

  // Depth of the job queue between the front and the back part.
  localparam int unsigned JobQueueDepth = 2;

  localparam logic [7:0] PadChar = 8'h3D;  // '='

  // Group phase codes: bytes already taken in the current three-byte group.
  localparam logic [1:0] PhaseFirst  = 2'd0;
  localparam logic [1:0] PhaseSecond = 2'd1;
  localparam logic [1:0] PhaseThird  = 2'd2;

  // One input byte turns into one job of one to four characters.
  typedef struct packed {
    logic [3:0][7:0] chars;      // chars[0] goes out first
    logic [1:0]      last_idx;   // index of the final character of the job
    logic            msg_end;    // the final character closes the message
  } b64e_job_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [7:0] b64e_sym(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/b64e_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front: byte intake and sextet split
// Tracks the group phase and leftover bits and builds one job per byte.
// ----------------------------------------------------------------------------
module b64e_front
  import b64e_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output b64e_job_t  job_o
);

  logic [1:0] group_phase_q, group_phase_d;
  logic [3:0] leftover_q, leftover_d;

  always_comb begin
    job_o          = '0;
    job_o.chars[2] = PadChar;
    job_o.chars[3] = PadChar;
    group_phase_d  = PhaseFirst;
    leftover_d     = 4'h0;
    unique case (group_phase_q)
      PhaseSecond: begin
        job_o.chars[0] = b64e_sym({leftover_q[1:0], data_byte_i[7:4]});
        if (last_byte_i) begin
          job_o.chars[1] = b64e_sym({data_byte_i[3:0], 2'b00});
          job_o.last_idx = 2'd2;
          job_o.msg_end  = 1'b1;
        end else begin
          group_phase_d = PhaseThird;
          leftover_d    = data_byte_i[3:0];
        end
      end
      PhaseThird: begin
        job_o.chars[0] = b64e_sym({leftover_q, data_byte_i[7:6]});
        job_o.chars[1] = b64e_sym(data_byte_i[5:0]);
        job_o.last_idx = 2'd1;
        job_o.msg_end  = last_byte_i;
      end
      default: begin
        // The unused fourth code behaves as the start of a group.
        job_o.chars[0] = b64e_sym(data_byte_i[7:2]);
        if (last_byte_i) begin
          job_o.chars[1] = b64e_sym({data_byte_i[1:0], 4'b0000});
          job_o.last_idx = 2'd3;
          job_o.msg_end  = 1'b1;
        end else begin
          group_phase_d = PhaseSecond;
          leftover_d    = {2'b00, data_byte_i[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_phase_q <= PhaseFirst;
      leftover_q    <= 4'h0;
    end else if (accept_i) begin
      group_phase_q <= group_phase_d;
      leftover_q    <= leftover_d;
    end
  end

endmodule

// ===== hw/rtl/b64e_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_queue: job queue
// Small first-in first-out store that decouples intake from character output.
// ----------------------------------------------------------------------------
module b64e_queue
  import b64e_pkg::*;
#(
  parameter int unsigned Depth = JobQueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  b64e_job_t push_job_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output b64e_job_t head_job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  b64e_job_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign head_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/b64e_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back: character serialiser
// Sends the characters of the head job one per cycle, while out_ready_i is high, through an output register.
// ----------------------------------------------------------------------------
module b64e_back
  import b64e_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  b64e_job_t  job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] char_q;
  logic       last_q;
  logic       load;
  logic       at_end;

  assign load   = (!valid_q || out_ready_i) && !empty_i;
  assign at_end = (idx_q == job_i.last_idx);
  assign pop_o  = load && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= job_i.chars[idx_q];
      last_q <= at_end && job_i.msg_end;
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

endmodule

// ===== hw/rtl/base64_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_encoder: streaming base64 encoder, standard alphabet
// One raw byte per input transaction, one ASCII character per output one.
// ----------------------------------------------------------------------------
// Takes a message one byte at a time, last_byte_i marking its final byte, and
// returns the base64 text one character at a time, padded with '=' to a whole
// group of four, with out_last_o on the final character. An empty message
// cannot be expressed and yields nothing. Each accepted byte is turned at once
// into a job of one to four characters and placed in a short queue; the back
// part drains that queue at one character per cycle, while out_ready_i is
// high, through a registered output. The output channel therefore sets the
// rate: a byte yields one character as the first or second byte of a group
// and two as the third, while a final byte yields four when it opens a group,
// three when it is the second of one and two when it closes one, so a long
// message gives four characters per three bytes. The input accepts a byte in
// any cycle in which the queue has room, also while a finished character
// waits at the output. When the block is otherwise idle, the first character
// of an accepted byte passes through the queue and then the output register.
// ----------------------------------------------------------------------------
module base64_encoder
  import b64e_pkg::*;
#(
  parameter int unsigned QueueDepth = JobQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);

  b64e_job_t new_job;
  b64e_job_t head_job;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  logic      accept;

  // A byte is taken whenever its job has a place in the queue.
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && !q_full;

  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .job_o       (new_job)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_job_i (new_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_job_o (head_job)
  );

  // The back part walks the characters of the head job and frees the entry
  // as its final character moves into the output register.
  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .job_i       (head_job),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o)
  );

endmodule

// ===== test/tb_base64_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_encoder: self-checking testbench of the streaming base64 encoder
// Drives bytes through a short directed table and then random messages, takes
// every expected character from hand-typed text or its own encoder model and
// compares each output transaction with the oldest expected character, under
// random stalls on both sides and one long hold-off at the output.
// ----------------------------------------------------------------------------
module tb_base64_encoder;
  import b64e_pkg::*;

  // One expected output transaction.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  localparam int unsigned TotalBytes = 410;
  localparam int unsigned DirRows    = 22;
  localparam int unsigned HoldCycles = 300;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic [7:0] data_byte   = 8'h00;
  logic       last_byte   = 1'b0;
  logic       out_ready   = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_char;
  logic       out_last;

  base64_encoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .data_byte_i (data_byte),
    .last_byte_i (last_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_char_o  (out_char),
    .out_last_o  (out_last)
  );

  // 12 ns period, high and low for half of it each.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model state: position in the three-byte group and the unsent low bits.
  logic [1:0] model_phase = PhaseFirst;
  logic [3:0] model_rest  = 4'h0;
  string      sextet_lut  = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  enc_char_t  expected_chars[$];  // characters still to come out, oldest first
  enc_char_t  fresh_chars[$];     // what the latest byte produced
  int         mismatch_count = 0;
  int         bytes_sent     = 0;
  bit         hold_request   = 1'b0;

  // Directed table. A non-empty text is the output typed in by hand for that
  // byte; an empty one leaves the row to the model.
  logic [7:0] dir_byte [DirRows] = '{
    8'h00, 8'hFF,                       // one-byte messages, field extremes
    8'h4D, 8'h61, 8'h6E,                // a whole group closed by the final byte
    8'h4D, 8'h61,                       // two-byte message, single pad
    8'hFF, 8'hFF, 8'hFF,                // all ones through every phase
    8'h00, 8'h00, 8'h00,                // all zeros through every phase
    8'hFF, 8'hFF,                       // all ones, closing on the second byte
    8'hA5, 8'h5A, 8'h3C, 8'hC3,         // group boundary crossed mid-message
    8'h01, 8'h80, 8'h7F
  };
  logic       dir_last [DirRows] = '{
    1'b1, 1'b1,
    1'b0, 1'b0, 1'b1,
    1'b0, 1'b1,
    1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b1,
    1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b1, 1'b1
  };
  string      dir_text [DirRows] = '{
    "AA==", "/w==",
    "T", "W", "Fu",
    "T", "WE=",
    "/", "/", "//",
    "A", "A", "AA",
    "/", "/8=",
    "", "", "", "",
    "", "", ""
  };

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    return sextet_lut[v];
  endfunction

  function automatic enc_char_t mk_char(input logic [7:0] c, input logic l);
    enc_char_t e;
    e.ch   = c;
    e.last = l;
    return e;
  endfunction

  // Encodes one byte into fresh_chars and advances the model state. The unused
  // fourth phase value is handled as the start of a group.
  task automatic encode_byte(input logic [7:0] b, input logic l);
    fresh_chars.delete();
    case (model_phase)
      PhaseSecond: begin
        fresh_chars.push_back(mk_char(sextet_char({model_rest[1:0], b[7:4]}), 1'b0));
        if (l) begin
          fresh_chars.push_back(mk_char(sextet_char({b[3:0], 2'b00}), 1'b0));
          fresh_chars.push_back(mk_char(PadChar, 1'b1));
          model_phase = PhaseFirst;
          model_rest  = 4'h0;
        end else begin
          model_phase = PhaseThird;
          model_rest  = b[3:0];
        end
      end
      PhaseThird: begin
        fresh_chars.push_back(mk_char(sextet_char({model_rest, b[7:6]}), 1'b0));
        fresh_chars.push_back(mk_char(sextet_char(b[5:0]), l));
        model_phase = PhaseFirst;
        model_rest  = 4'h0;
      end
      default: begin
        fresh_chars.push_back(mk_char(sextet_char(b[7:2]), 1'b0));
        if (l) begin
          fresh_chars.push_back(mk_char(sextet_char({b[1:0], 4'h0}), 1'b0));
          fresh_chars.push_back(mk_char(PadChar, 1'b0));
          fresh_chars.push_back(mk_char(PadChar, 1'b1));
          model_phase = PhaseFirst;
          model_rest  = 4'h0;
        end else begin
          model_phase = PhaseSecond;
          model_rest  = {2'b00, b[1:0]};
        end
      end
    endcase
  endtask

  // Offers one byte after an idle gap and returns just after the rising edge
  // at which it was accepted. Valid is only lowered when there is a gap, so a
  // back-to-back byte never sees two assignments to it in one time step.
  task automatic send_byte(input logic [7:0] b, input logic l, input int unsigned gap,
                           input string text);
    bit taken;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    do begin
      // Handshake inputs only move at the rising edge, so the falling edge
      // shows what the next rising edge will see.
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    bytes_sent++;
    encode_byte(b, l);
    if (text.len() == 0) begin
      foreach (fresh_chars[i]) expected_chars.push_back(fresh_chars[i]);
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        expected_chars.push_back(mk_char(text[i], (i == text.len() - 1) ? l : 1'b0));
      end
    end
  endtask

  // Sender: reset, the directed table, then random messages until the byte
  // budget is used up, and finally the drain and the verdict.
  initial begin
    int unsigned msg_len;
    int unsigned msg_count;
    bit          calm;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DirRows; r++) begin
      send_byte(dir_byte[r], dir_last[r], $urandom_range(0, 9), dir_text[r]);
    end

    msg_count = 0;
    while (bytes_sent < TotalBytes) begin
      // Mostly short messages so that every phase ends a message often; now
      // and then a long one to run many groups back to back.
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      if (msg_len > TotalBytes - bytes_sent) begin
        msg_len = TotalBytes - bytes_sent;
      end
      calm = ($urandom_range(0, 3) == 0);
      // Early on, the receiver stops for a long stretch while bytes keep
      // coming, so the job queue fills and the input has to stall.
      if (msg_count == 3) begin
        hold_request = 1'b1;
      end
      for (int unsigned k = 0; k < msg_len; k++) begin
        send_byte(8'($urandom_range(0, 255)), (k == msg_len - 1),
                  calm ? 0 : $urandom_range(0, 9), "");
      end
      msg_count++;
    end
    in_valid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    // A few more cycles so that any surplus character would still be seen.
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver: for each character it draws a stall, with calm stretches, and
  // once it holds ready low for a long time on request from the sender.
  initial begin
    int unsigned stall;
    int unsigned calm_left;
    bit          calm;
    bit          taken;
    calm_left = 0;
    calm      = 1'b0;
    @(posedge clk);
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(5, 30);
      end
      calm_left--;
      stall = calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        taken = out_valid;
        @(posedge clk);
      end while (!taken);
    end
  end

  // Checker: every output transaction against the oldest expected character.
  always @(negedge clk) begin
    enc_char_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character, actual char %h last %b",
                 $realtime, out_char, out_last);
        mismatch_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_char !== want.ch) begin
          $display("%0t: out_char mismatch, expected %h actual %h",
                   $realtime, want.ch, out_char);
          mismatch_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: out_last mismatch, expected %b actual %b",
                   $realtime, want.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
